// File: rtl/core/lz77_window_decompressor_top_assert.svh
// assertion macros for the lz77 window decompressor core
// no dependencies; taken in by files that carry concurrent checks
`ifndef LZ77_WINDOW_DECOMPRESSOR_TOP_ASSERT_SVH
`define LZ77_WINDOW_DECOMPRESSOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define LZWD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzwd same-cycle check failed");

`define LZWD_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzwd next-cycle check failed");

`else

`define LZWD_ASSERT_IMP(name, clk, rst, ante, cons)

`define LZWD_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/lzwd_pkg.sv
// shared types and constants for the lz77 window decompressor
// no dependencies
package lzwd_pkg;

   typedef logic [7:0] byte_type;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_ITEM,
      PH_HIGH
   } phase_type;

   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_DECRYPT_ENABLE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_LENGTH = 1'b1;

   localparam int TOKEN_SRC_LSB = 4;
   localparam int TOKEN_LEN_W   = 4;
   localparam int FLAG_IDX_W    = 3;

endpackage

// File: rtl/core/lzwd_window.sv
// history window ram: one write port and one registered read port
// depends on lzwd_pkg
module lzwd_window #(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  lzwd_pkg::byte_type       wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output lzwd_pkg::byte_type       rd_data
);

   lzwd_pkg::byte_type window_ff [DEPTH];
   lzwd_pkg::byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         window_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= window_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lz77_window_decompressor_top.sv
// lz77 window decompressor top level: byte descrambler, token sequencer, output register
// depends on lzwd_pkg, lzwd_window and lz77_window_decompressor_top_assert.svh
//
// One compressed byte is taken per transaction while the sequencer is idle. A flag byte, a
// literal or the low half of a token is handled in decode; the high half of a copy token
// copies 2 to 17 bytes, each one read of the single window read port then one write of the
// same byte; an end token or a final input byte adds the closing result. A stalled result
// register holds the sequencer in place. The window needs no clearing pass if entries are
// only read after the chunk has written them; the user must ensure this, the block does not.
`include "lz77_window_decompressor_top_assert.svh"

module lz77_window_decompressor_top #(
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lzwd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                          csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_in_byte,
   input  logic                                 req_chunk_start,
   input  logic                                 req_last_input,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_out_byte,
   output logic                                 rsp_has_byte,
   output logic                                 rsp_run_last,
   output logic                                 rsp_end_of_chunk,
   output logic                                 rsp_size_ok,
   output logic                                 rsp_truncated
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int LW = lzwd_pkg::TOKEN_LEN_W;
   localparam int CW = LW + 1;
   localparam int FW = lzwd_pkg::FLAG_IDX_W;
   localparam logic [FW-1:0] FLAG_IDX_LAST = FW'((1 << FW) - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_EMIT,
      S_CLOSE
   } state_type;

   state_type           state_ff, state_in;
   logic                decrypt_enable_ff, decrypt_enable_in;
   logic [31:0]         expected_length_ff, expected_length_in;
   logic [7:0]          byte_offset_ff, byte_offset_in;
   logic [AW-1:0]       wptr_ff, wptr_in;
   lzwd_pkg::byte_type  flag_bits_ff, flag_bits_in;
   logic [FW-1:0]       flag_index_ff, flag_index_in;
   lzwd_pkg::phase_type phase_ff, phase_in;
   lzwd_pkg::byte_type  token_low_ff, token_low_in;
   logic [31:0]         out_count_ff, out_count_in;
   logic                chunk_done_ff, chunk_done_in;
   lzwd_pkg::byte_type  cur_byte_ff, cur_byte_in;
   logic                last_ff, last_in;
   logic                ended_ff, ended_in;
   logic [AW-1:0]       src_ff, src_in;
   logic [CW-1:0]       len_ff, len_in;

   logic                rsp_valid_ff, rsp_valid_in;
   lzwd_pkg::byte_type  rsp_byte_ff, rsp_byte_in;
   logic                rsp_has_ff, rsp_has_in;
   logic                rsp_run_last_ff, rsp_run_last_in;
   logic                rsp_end_ff, rsp_end_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic                rsp_trunc_ff, rsp_trunc_in;

   logic                accept;
   logic                out_free;
   logic                eff_done;
   logic [7:0]          eff_offset;
   logic [15:0]         token;
   logic [AW-1:0]       token_src;
   state_type           after_item;
   logic                emit;
   lzwd_pkg::byte_type  emit_data;
   logic                emit_last;
   logic                advance;

   logic                win_wr_en;
   logic                win_rd_en;
   lzwd_pkg::byte_type  win_rd_data;

   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign token      = {cur_byte_ff, token_low_ff};
   assign token_src  = token[lzwd_pkg::TOKEN_SRC_LSB +: AW];
   assign after_item = last_ff ? S_CLOSE : S_IDLE;
   assign eff_done   = req_chunk_start ? 1'b0 : chunk_done_ff;
   assign eff_offset = req_chunk_start ? 8'd0 : byte_offset_ff;
   assign win_rd_en  = (state_ff == S_READ);

   always_comb begin
      state_in           = state_ff;
      decrypt_enable_in  = decrypt_enable_ff;
      expected_length_in = expected_length_ff;
      byte_offset_in     = byte_offset_ff;
      wptr_in            = wptr_ff;
      flag_bits_in       = flag_bits_ff;
      flag_index_in      = flag_index_ff;
      phase_in           = phase_ff;
      token_low_in       = token_low_ff;
      out_count_in       = out_count_ff;
      chunk_done_in      = chunk_done_ff;
      cur_byte_in        = cur_byte_ff;
      last_in            = last_ff;
      ended_in           = ended_ff;
      src_in             = src_ff;
      len_in             = len_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_byte_in        = rsp_byte_ff;
      rsp_has_in         = rsp_has_ff;
      rsp_run_last_in    = rsp_run_last_ff;
      rsp_end_in         = rsp_end_ff;
      rsp_ok_in          = rsp_ok_ff;
      rsp_trunc_in       = rsp_trunc_ff;
      emit               = 1'b0;
      emit_data          = cur_byte_ff;
      emit_last          = 1'b0;
      advance            = 1'b0;
      win_wr_en          = 1'b0;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            lzwd_pkg::CSR_DECRYPT_ENABLE:  decrypt_enable_in  = csr_data[0];
            lzwd_pkg::CSR_EXPECTED_LENGTH: expected_length_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_chunk_start) begin
                  wptr_in       = AW'(1);
                  flag_bits_in  = '0;
                  flag_index_in = '0;
                  phase_in      = lzwd_pkg::PH_FLAG;
                  token_low_in  = '0;
                  byte_offset_in = '0;
                  out_count_in  = '0;
                  chunk_done_in = 1'b0;
               end
               if (!eff_done) begin
                  cur_byte_in    = decrypt_enable_ff ?
                                   ((req_in_byte - eff_offset) ^ eff_offset) : req_in_byte;
                  byte_offset_in = eff_offset + 8'd1;
                  last_in        = req_last_input;
                  ended_in       = 1'b0;
                  state_in       = S_DECODE;
               end
            end
         end
         S_DECODE: begin
            unique case (phase_ff)
               lzwd_pkg::PH_FLAG: begin
                  flag_bits_in  = cur_byte_ff;
                  flag_index_in = '0;
                  phase_in      = lzwd_pkg::PH_ITEM;
                  state_in      = after_item;
               end
               lzwd_pkg::PH_ITEM: begin
                  if (!flag_bits_ff[flag_index_ff]) begin
                     if (out_free) begin
                        emit      = 1'b1;
                        emit_data = cur_byte_ff;
                        emit_last = !last_ff;
                        advance   = 1'b1;
                        state_in  = after_item;
                     end
                  end else begin
                     token_low_in = cur_byte_ff;
                     phase_in     = lzwd_pkg::PH_HIGH;
                     state_in     = after_item;
                  end
               end
               lzwd_pkg::PH_HIGH: begin
                  phase_in = lzwd_pkg::PH_ITEM;
                  if (token_src == '0) begin
                     ended_in = 1'b1;
                     state_in = S_CLOSE;
                  end else begin
                     src_in   = token_src;
                     len_in   = CW'(token_low_ff[LW-1:0]) + CW'(1);
                     state_in = S_READ;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = win_rd_data;
               emit_last = (len_ff == '0) && !last_ff;
               src_in    = src_ff + AW'(1);
               if (len_ff == '0) begin
                  advance  = 1'b1;
                  state_in = after_item;
               end else begin
                  len_in   = len_ff - CW'(1);
                  state_in = S_READ;
               end
            end
         end
         S_CLOSE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_byte_in     = '0;
               rsp_has_in      = 1'b0;
               rsp_run_last_in = 1'b1;
               rsp_end_in      = 1'b1;
               rsp_ok_in       = (out_count_ff == expected_length_ff);
               rsp_trunc_in    = !ended_ff;
               chunk_done_in   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // byte result: goes out and into the window
      if (emit) begin
         rsp_valid_in    = 1'b1;
         rsp_byte_in     = emit_data;
         rsp_has_in      = 1'b1;
         rsp_run_last_in = emit_last;
         rsp_end_in      = 1'b0;
         rsp_ok_in       = 1'b0;
         rsp_trunc_in    = 1'b0;
         win_wr_en       = 1'b1;
         wptr_in         = wptr_ff + AW'(1);
         out_count_in    = out_count_ff + 32'd1;
      end

      // next flag bit, fetch a new flag byte after eight items
      if (advance) begin
         if (flag_index_ff == FLAG_IDX_LAST) begin
            flag_index_in = '0;
            phase_in      = lzwd_pkg::PH_FLAG;
         end else begin
            flag_index_in = flag_index_ff + FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         decrypt_enable_ff  <= 1'b0;
         expected_length_ff <= '0;
         byte_offset_ff     <= '0;
         wptr_ff            <= AW'(1);
         flag_bits_ff       <= '0;
         flag_index_ff      <= '0;
         phase_ff           <= lzwd_pkg::PH_FLAG;
         token_low_ff       <= '0;
         out_count_ff       <= '0;
         chunk_done_ff      <= 1'b0;
         last_ff            <= 1'b0;
         ended_ff           <= 1'b0;
         len_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         decrypt_enable_ff  <= decrypt_enable_in;
         expected_length_ff <= expected_length_in;
         byte_offset_ff     <= byte_offset_in;
         wptr_ff            <= wptr_in;
         flag_bits_ff       <= flag_bits_in;
         flag_index_ff      <= flag_index_in;
         phase_ff           <= phase_in;
         token_low_ff       <= token_low_in;
         out_count_ff       <= out_count_in;
         chunk_done_ff      <= chunk_done_in;
         last_ff            <= last_in;
         ended_ff           <= ended_in;
         len_ff             <= len_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      cur_byte_ff     <= cur_byte_in;
      src_ff          <= src_in;
      rsp_byte_ff     <= rsp_byte_in;
      rsp_has_ff      <= rsp_has_in;
      rsp_run_last_ff <= rsp_run_last_in;
      rsp_end_ff      <= rsp_end_in;
      rsp_ok_ff       <= rsp_ok_in;
      rsp_trunc_ff    <= rsp_trunc_in;
   end

   lzwd_window #(
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (wptr_ff),
      .wr_data (rsp_byte_in),
      .rd_en   (win_rd_en),
      .rd_addr (src_ff),
      .rd_data (win_rd_data)
   );

   assign csr_ready        = 1'b1;
   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_has_byte     = rsp_has_ff;
   assign rsp_run_last     = rsp_run_last_ff;
   assign rsp_end_of_chunk = rsp_end_ff;
   assign rsp_size_ok      = rsp_ok_ff;
   assign rsp_truncated    = rsp_trunc_ff;

   // closing transaction carries no byte and ends the run
   `LZWD_ASSERT_IMP(a_close_shape, clock, reset, rsp_valid && rsp_end_of_chunk, rsp_run_last && !rsp_has_byte)
   // a transaction without a byte is always the closing one
   `LZWD_ASSERT_IMP(a_nobyte_is_close, clock, reset, rsp_valid && !rsp_has_byte, rsp_end_of_chunk)
   // window data is used in S_EMIT only after S_READ issued its read, or while S_EMIT is held
   `LZWD_ASSERT_IMP(a_emit_after_read, clock, reset, state_ff == S_EMIT, $past(state_ff) == S_READ || $past(state_ff) == S_EMIT)
   // every copied byte counts once
   `LZWD_ASSERT_NXT(a_copy_count, clock, reset, state_ff == S_EMIT && out_free, out_count_ff == $past(out_count_ff) + 32'd1)

endmodule

// File: verif/lzwd_tb_pkg.sv
// scoreboard for the lz77 window decompressor testbench: decodes each accepted transaction
// into the results the block should return and checks them in order as they come out
// depends on lzwd_pkg
package lzwd_tb_pkg;

   localparam int HISTORY_DEPTH = 4096;
   localparam int FW = lzwd_pkg::FLAG_IDX_W;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_last;
      logic       end_of_chunk;
      logic       size_ok;
      logic       truncated;
   } decomp_out_type;

   class decomp_scoreboard;
      lzwd_pkg::byte_type     history [HISTORY_DEPTH];
      logic [11:0]            wr_ptr;
      logic [7:0]             flag_bits;
      logic [FW-1:0]          flag_index;
      lzwd_pkg::phase_type    phase;
      logic [7:0]             token_low;
      logic [7:0]             offset;
      logic [31:0]            count;
      bit                     done;
      bit                     decrypt;
      logic [31:0]            expected_len;
      decomp_out_type         pending_outputs[$];
      int                     errors;
      int                     results_checked;
      int                     bytes_decoded;
      int                     chunks_closed;

      function new();
         foreach (history[k]) history[k] = '0;
         decrypt = 1'b0;
         expected_len = '0;
         errors = 0;
         results_checked = 0;
         bytes_decoded = 0;
         chunks_closed = 0;
         restart_chunk();
      endfunction

      function void restart_chunk();
         wr_ptr = 12'd1;
         flag_bits = '0;
         flag_index = '0;
         phase = lzwd_pkg::PH_FLAG;
         token_low = '0;
         offset = '0;
         count = '0;
         done = 1'b0;
      endfunction

      function void set_reg(logic [lzwd_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] value);
         case (idx)
            lzwd_pkg::CSR_DECRYPT_ENABLE: decrypt = value[0];
            lzwd_pkg::CSR_EXPECTED_LENGTH: expected_len = value;
            default: ;
         endcase
      endfunction

      function void put_byte(logic [7:0] value);
         decomp_out_type r;
         r = '0;
         r.out_byte = value;
         r.has_byte = 1'b1;
         pending_outputs.push_back(r);
         history[wr_ptr] = value;
         wr_ptr = wr_ptr + 12'd1;
         count = count + 32'd1;
      endfunction

      function void advance_flag();
         if (flag_index == '1) phase = lzwd_pkg::PH_FLAG;
         flag_index = flag_index + FW'(1);
      endfunction

      function void decode_byte(logic [7:0] raw, logic start_bit, logic last_bit);
         logic [7:0]     b;
         logic [15:0]    tok;
         logic [11:0]    src;
         int             len;
         int             first_idx;
         bit             ended;
         decomp_out_type r;
         first_idx = pending_outputs.size();
         ended = 1'b0;
         if (start_bit) restart_chunk();
         if (done) return;
         bytes_decoded++;
         b = raw;
         if (decrypt) b = (raw - offset) ^ offset;
         offset = offset + 8'd1;
         case (phase)
            lzwd_pkg::PH_FLAG: begin
               flag_bits = b;
               flag_index = '0;
               phase = lzwd_pkg::PH_ITEM;
            end
            lzwd_pkg::PH_ITEM: begin
               if (!flag_bits[flag_index]) begin
                  put_byte(b);
                  advance_flag();
               end else begin
                  token_low = b;
                  phase = lzwd_pkg::PH_HIGH;
               end
            end
            default: begin
               tok = {b, token_low};
               src = tok[15:lzwd_pkg::TOKEN_SRC_LSB];
               phase = lzwd_pkg::PH_ITEM;
               if (src == '0) begin
                  ended = 1'b1;
               end else begin
                  len = int'(tok[lzwd_pkg::TOKEN_LEN_W-1:0]) + 2;
                  repeat (len) begin
                     put_byte(history[src]);
                     src = src + 12'd1;
                  end
                  advance_flag();
               end
            end
         endcase
         if (ended || last_bit) begin
            r = '0;
            r.end_of_chunk = 1'b1;
            r.size_ok = (count == expected_len);
            r.truncated = !ended;
            pending_outputs.push_back(r);
            done = 1'b1;
            chunks_closed++;
         end
         if (pending_outputs.size() > first_idx)
            pending_outputs[pending_outputs.size() - 1].run_last = 1'b1;
      endfunction

      function void note_field(string name, logic [7:0] want, logic [7:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void compare_output(decomp_out_type seen);
         decomp_out_type want;
         if (pending_outputs.size() == 0) begin
            $display("%0t: result with nothing outstanding, expected none, got out_byte %0h end %0b",
                     $time, seen.out_byte, seen.end_of_chunk);
            errors++;
            return;
         end
         want = pending_outputs.pop_front();
         results_checked++;
         note_field("out_byte", want.out_byte, seen.out_byte);
         note_field("has_byte", 8'(want.has_byte), 8'(seen.has_byte));
         note_field("run_last", 8'(want.run_last), 8'(seen.run_last));
         note_field("end_of_chunk", 8'(want.end_of_chunk), 8'(seen.end_of_chunk));
         note_field("size_ok", 8'(want.size_ok), 8'(seen.size_ok));
         note_field("truncated", 8'(want.truncated), 8'(seen.truncated));
      endfunction

      function int pending();
         return pending_outputs.size();
      endfunction
   endclass

endpackage

// File: verif/lz77_window_decompressor_top_tb.sv
// top-level testbench for lz77_window_decompressor_top: directed chunks, then random
// well-formed and broken chunks under varying back-pressure, checked against lzwd_tb_pkg
// depends on lzwd_pkg, lzwd_tb_pkg and the decompressor rtl
module lz77_window_decompressor_top_tb;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS  = 24;
   localparam int LONG_OUTPUTS  = 2150;
   localparam int LONG_EXPECTED = 2160;
   localparam int HOLD_CYCLES   = 400;

   typedef enum int {
      END_TOKEN,
      END_TRUNC,
      END_RESTART
   } chunk_end_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [lzwd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]                      csr_data = '0;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [7:0]                       req_in_byte = '0;
   logic                             req_chunk_start = 1'b0;
   logic                             req_last_input = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [7:0]                       rsp_out_byte;
   logic                             rsp_has_byte;
   logic                             rsp_run_last;
   logic                             rsp_end_of_chunk;
   logic                             rsp_size_ok;
   logic                             rsp_truncated;

   lzwd_tb_pkg::decomp_scoreboard sb;
   lzwd_tb_pkg::decomp_out_type   rsp_seen;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               hold_len = 0;
   int               hold_left = 0;
   bit               hold_taken = 1'b0;
   int               cycle_count = 0;

   int               plan_left = 0;
   chunk_end_type    end_style = END_TOKEN;
   logic [7:0]       high_pending = '0;
   bit               long_mode = 1'b0;
   bit               force_start = 1'b0;

   always #6 clock = ~clock;

   lz77_window_decompressor_top dut (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL lz77_window_decompressor_top");
         $finish;
      end
   end

   // receiver: check each accepted result, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen = {rsp_out_byte, rsp_has_byte, rsp_run_last, rsp_end_of_chunk,
                     rsp_size_ok, rsp_truncated};
         sb.compare_output(rsp_seen);
      end
      if (hold_len != 0 && !hold_taken) begin
         hold_left = hold_len;
         hold_taken = 1'b1;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_item(input logic [7:0] value, input logic start_bit,
                            input logic last_bit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= value;
      req_chunk_start <= start_bit;
      req_last_input <= last_bit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.decode_byte(value, start_bit, last_bit);
   endtask

   task automatic write_reg(input logic [lzwd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic configure(input logic decrypt_on, input logic [31:0] length);
      write_reg(lzwd_pkg::CSR_DECRYPT_ENABLE, {31'd0, decrypt_on});
      write_reg(lzwd_pkg::CSR_EXPECTED_LENGTH, length);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // builds the next compressed byte from the predicted parser state so that copies
   // only ever read window entries the current chunk has already written
   function automatic void next_item(output logic [7:0] value, output logic start_bit,
                                     output logic last_bit);
      logic [7:0]          plain;
      logic [7:0]          key;
      logic [15:0]         tok;
      lzwd_pkg::phase_type ph;
      int                  cnt;
      int                  lim;
      int                  src;
      bit                  closing;
      start_bit = 1'b0;
      last_bit = 1'b0;
      if (sb.done && !long_mode && !force_start && $urandom_range(3) == 0) begin
         value = 8'($urandom);
         last_bit = 1'($urandom_range(1));
         return;
      end
      if (sb.done || force_start || (plan_left <= 0 && end_style == END_RESTART)) begin
         start_bit = 1'b1;
         force_start = 1'b0;
         if (long_mode)
            plan_left = 1 << 30;
         else if ($urandom_range(7) == 0)
            plan_left = $urandom_range(40, 90);
         else
            plan_left = $urandom_range(1, 24);
         end_style = long_mode ? END_TOKEN : chunk_end_type'($urandom_range(2));
      end
      ph = start_bit ? lzwd_pkg::PH_FLAG : sb.phase;
      cnt = start_bit ? 0 : int'(sb.count);
      key = start_bit ? 8'd0 : sb.offset;
      closing = (plan_left <= 0) || (long_mode && cnt >= LONG_OUTPUTS);
      plan_left--;
      case (ph)
         lzwd_pkg::PH_FLAG: begin
            if (long_mode)
               plain = (cnt == 0) ? 8'hFE : 8'hFF;
            else
               plain = 8'($urandom);
            // nothing to copy yet, so the first item must be a literal
            if (cnt == 0 && !closing) plain[0] = 1'b0;
            if (closing && end_style == END_TOKEN) plain[0] = 1'b1;
         end
         lzwd_pkg::PH_ITEM: begin
            if (!sb.flag_bits[sb.flag_index]) begin
               plain = 8'($urandom);
            end else begin
               if ((closing && end_style == END_TOKEN) || cnt == 0) begin
                  src = 0;
               end else begin
                  lim = (cnt > 4095) ? 4095 : cnt;
                  case ($urandom_range(2))
                     0: src = lim;
                     1: src = lim - $urandom_range(0, (lim - 1 < 24) ? lim - 1 : 24);
                     default: src = $urandom_range(1, lim);
                  endcase
               end
               tok = {12'(src), long_mode ? 4'hF : 4'($urandom_range(15))};
               plain = tok[7:0];
               high_pending = tok[15:8];
            end
         end
         default: plain = high_pending;
      endcase
      if (closing && end_style == END_TRUNC)
         last_bit = 1'b1;
      else if (closing && end_style == END_TOKEN && ph == lzwd_pkg::PH_HIGH)
         last_bit = 1'($urandom_range(1));
      value = sb.decrypt ? ((plain ^ key) + key) : plain;
   endfunction

   task automatic run_random(input int quota);
      int         taken;
      logic [7:0] value;
      logic       start_bit;
      logic       last_bit;
      bit         ignored;
      taken = 0;
      while (taken < quota) begin
         next_item(value, start_bit, last_bit);
         ignored = sb.done && !start_bit;
         send_item(value, start_bit, last_bit);
         if (!ignored) taken++;
      end
   endtask

   initial begin
      logic [7:0] value;
      logic       start_bit;
      logic       last_bit;
      sb = new();
      send_idle_pct = 33;
      recv_idle_pct = 87;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      configure(1'b0, 32'd21);

      // literals at both extremes, longest overlapping copy, shortest copy, end token
      send_item(8'h1C, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h1F, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h20, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h0F, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      // empty chunk closed by an end token that is also the final input byte
      send_item(8'h01, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      // bytes after the chunk has closed
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b0);
      // input runs out after literals, on a flag byte and inside a token
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h80, 1'b0, 1'b0);
      send_item(8'h7F, 1'b0, 1'b1);
      send_item(8'h55, 1'b1, 1'b1);
      send_item(8'h02, 1'b1, 1'b0);
      send_item(8'h11, 1'b0, 1'b0);
      send_item(8'h10, 1'b0, 1'b1);
      drain();

      configure(1'b1, 32'd0);
      run_random(RANDOM_ITEMS);
      drain();

      send_idle_pct = 87;
      recv_idle_pct = 33;
      configure(1'b0, 32'hFFFF_FFFF);
      run_random(RANDOM_ITEMS);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(1'b1, 32'd12);
      hold_len = HOLD_CYCLES;
      run_random(RANDOM_ITEMS);
      drain();

      // one chunk of maximum-length copies that wraps the byte offset
      configure(1'b1, 32'(LONG_EXPECTED));
      long_mode = 1'b1;
      force_start = 1'b1;
      do begin
         next_item(value, start_bit, last_bit);
         send_item(value, start_bit, last_bit);
      end while (!sb.done);
      long_mode = 1'b0;
      drain();

      $display("decoded %0d compressed bytes into %0d checked results over %0d closed chunks",
               sb.bytes_decoded, sb.results_checked, sb.chunks_closed);
      $display("plain and descrambled input, end tokens, truncation, ignored bytes, %s",
               "long output hold-off and a chunk that wraps the byte offset");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS lz77_window_decompressor_top");
      end else begin
         $display("FAIL lz77_window_decompressor_top");
      end
      $finish;
   end

endmodule
